[hdl/source_text_tokenizer_assert.svh]
// ----------------------------------------------------------------------------
// source_text_tokenizer_assert
// Assertion macros shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define STT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// antecedent implies consequent in the next cycle
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int POS_BITS  = 32;
    localparam int OUT_POS_W = 32;
    localparam int VALUE_W   = 63;
    localparam int KIND_W    = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [POS_BITS-1:0]  t_pos;
    typedef logic [OUT_POS_W-1:0] t_out_pos;
    typedef logic [7:0]           t_byte;

    localparam t_kind K_INT    = t_kind'(0);
    localparam t_kind K_IDENT  = t_kind'(1);
    localparam t_kind K_VAR    = t_kind'(2);
    localparam t_kind K_KWINT  = t_kind'(3);
    localparam t_kind K_EQUALS = t_kind'(4);
    localparam t_kind K_SEMI   = t_kind'(5);
    localparam t_kind K_COLON  = t_kind'(6);
    localparam t_kind K_END    = t_kind'(7);
    localparam t_kind K_ERROR  = t_kind'(8);

    localparam t_value VALUE_MAX = '1;

    localparam t_byte CH_EQUALS = 8'h3d;
    localparam t_byte CH_SEMI   = 8'h3b;
    localparam t_byte CH_COLON  = 8'h3a;

    typedef struct packed {
        t_kind    kind;
        t_value   value;
        logic     overflow;
        t_out_pos start_pos;
        t_out_pos end_pos;
        logic     last;
    } t_tok;

endpackage

[hdl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: bytes in, integer / identifier / keyword / punctuation
// tokens, plus end and error tokens, out with byte offsets.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | i_ch, i_end_of_text
//  output  | out       | o_valid / i_stall    | o_kind, o_value, o_overflow,
//          |           |                      | o_start_pos, o_end_pos, o_last
//
//  One byte is taken per cycle while o_stall is low; its tokens are registered into the result queue.
//  A byte gives up to two tokens; they leave through a 4-word result queue
//  at one word per cycle while i_stall is low, so a byte that ends two tokens gives two output words.
//  o_stall rises while the queue cannot take two more words.
//  Synchronous reset empties the queue and returns the lexer to idle.
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  stt_pkg::t_byte    i_ch,
    input  logic              i_end_of_text,
    output logic              o_valid,
    input  logic              i_stall,
    output stt_pkg::t_kind    o_kind,
    output stt_pkg::t_value   o_value,
    output logic              o_overflow,
    output stt_pkg::t_out_pos o_start_pos,
    output stt_pkg::t_out_pos o_end_pos,
    output logic              o_last
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_WORD,
        MODE_ERROR
    } t_mode;

    t_mode            r_mode, n_mode;
    t_value           r_num, n_num;
    logic             r_ovf, n_ovf;
    t_pos             r_start, n_start;
    t_pos             r_pos, n_pos;
    t_byte [2:0]      r_pfx, n_pfx;
    logic [2:0]       r_len, n_len;

    t_tok             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_CW-1:0]  r_cnt;

    logic             acc, pop;
    logic [1:0]       n_push;
    t_tok             tok0, tok1, flush_tok, one_tok;
    logic             flush_vld;
    logic             is_digit, is_alpha, is_space;
    logic [VALUE_W+3:0] prod;
    t_pos             pos_inc;

    assign acc      = i_valid && !o_stall;
    assign pop      = o_valid && !i_stall;
    assign o_stall  = r_cnt > Q_CW'(Q_DEPTH - 2);
    assign o_valid  = r_cnt != '0;

    assign is_digit = i_ch >= 8'h30 && i_ch <= 8'h39;
    assign is_alpha = (i_ch >= 8'h61 && i_ch <= 8'h7a) || (i_ch >= 8'h41 && i_ch <= 8'h5a);
    assign is_space = i_ch == 8'h20 || (i_ch >= 8'h09 && i_ch <= 8'h0d);
    assign pos_inc  = r_pos + t_pos'(1);
    assign prod     = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1) + (VALUE_W+4)'(i_ch[3:0]);

    always_comb begin
        flush_tok           = '0;
        flush_vld           = r_mode == MODE_NUMBER || r_mode == MODE_WORD;
        flush_tok.start_pos = OUT_POS_W'(r_start);
        flush_tok.end_pos   = OUT_POS_W'(r_pos);
        if (r_mode == MODE_NUMBER) begin
            flush_tok.kind     = K_INT;
            flush_tok.value    = r_num;
            flush_tok.overflow = r_ovf;
        end else if (r_len == 3'd3 && r_pfx[0] == "v" && r_pfx[1] == "a" && r_pfx[2] == "r") begin
            flush_tok.kind = K_VAR;
        end else if (r_len == 3'd3 && r_pfx[0] == "i" && r_pfx[1] == "n" && r_pfx[2] == "t") begin
            flush_tok.kind = K_KWINT;
        end else begin
            flush_tok.kind = K_IDENT;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_num   = r_num;
        n_ovf   = r_ovf;
        n_start = r_start;
        n_pos   = r_pos;
        n_pfx   = r_pfx;
        n_len   = r_len;
        n_push  = 2'd0;
        tok0    = '0;
        tok1    = '0;
        one_tok = '0;
        one_tok.start_pos = OUT_POS_W'(r_pos);
        one_tok.end_pos   = OUT_POS_W'(pos_inc);

        if (i_end_of_text) begin
            one_tok.kind    = K_END;
            one_tok.end_pos = OUT_POS_W'(r_pos);
            if (r_mode != MODE_ERROR) begin
                if (flush_vld) begin
                    tok0   = flush_tok;
                    tok1   = one_tok;
                    n_push = 2'd2;
                end else begin
                    tok0   = one_tok;
                    n_push = 2'd1;
                end
            end
            n_mode  = MODE_IDLE;
            n_num   = '0;
            n_ovf   = 1'b0;
            n_start = '0;
            n_pos   = '0;
            n_pfx   = '0;
            n_len   = '0;
        end else if (r_mode == MODE_ERROR) begin
            n_mode = MODE_ERROR;
        end else if (r_mode == MODE_NUMBER && is_digit) begin
            if (r_ovf || prod[VALUE_W+3:VALUE_W] != '0) begin
                n_num = VALUE_MAX;
                n_ovf = 1'b1;
            end else begin
                n_num = prod[VALUE_W-1:0];
            end
            n_pos = pos_inc;
        end else if (r_mode == MODE_WORD && (is_alpha || is_digit)) begin
            if (r_len < 3'd3) begin
                n_pfx[r_len[1:0]] = i_ch;
            end
            if (r_len < 3'd4) begin
                n_len = r_len + 3'd1;
            end
            n_pos = pos_inc;
        end else begin
            n_mode = MODE_IDLE;
            n_pos  = pos_inc;
            n_push = {1'b0, flush_vld};
            tok0   = flush_tok;
            if (is_space) begin
                one_tok.kind = K_END;
            end else if (is_digit) begin
                n_mode  = MODE_NUMBER;
                n_start = r_pos;
                n_num   = VALUE_W'(i_ch[3:0]);
                n_ovf   = 1'b0;
            end else if (is_alpha) begin
                n_mode  = MODE_WORD;
                n_start = r_pos;
                n_pfx   = {8'h00, 8'h00, i_ch};
                n_len   = 3'd1;
            end else begin
                n_push = n_push + 2'd1;
                if (i_ch == CH_EQUALS) begin
                    one_tok.kind = K_EQUALS;
                end else if (i_ch == CH_SEMI) begin
                    one_tok.kind = K_SEMI;
                end else if (i_ch == CH_COLON) begin
                    one_tok.kind = K_COLON;
                end else begin
                    one_tok.kind = K_ERROR;
                    n_mode       = MODE_ERROR;
                end
                if (flush_vld) begin
                    tok1 = one_tok;
                end else begin
                    tok0 = one_tok;
                end
            end
        end

        if (n_push == 2'd2) begin
            tok1.last = 1'b1;
        end else begin
            tok0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_num   <= '0;
            r_ovf   <= 1'b0;
            r_start <= '0;
            r_pos   <= '0;
            r_pfx   <= '0;
            r_len   <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (acc) begin
                r_mode  <= n_mode;
                r_num   <= n_num;
                r_ovf   <= n_ovf;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_pfx   <= n_pfx;
                r_len   <= n_len;
                r_wr    <= r_wr + Q_AW'(n_push);
            end
            if (pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= r_cnt + (acc ? Q_CW'(n_push) : '0) - (pop ? Q_CW'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && n_push != 2'd0) begin
            r_q[r_wr] <= tok0;
        end
        if (acc && n_push == 2'd2) begin
            r_q[r_wr + Q_AW'(1)] <= tok1;
        end
    end

    assign o_kind      = r_q[r_rd].kind;
    assign o_value     = r_q[r_rd].value;
    assign o_overflow  = r_q[r_rd].overflow;
    assign o_start_pos = r_q[r_rd].start_pos;
    assign o_end_pos   = r_q[r_rd].end_pos;
    assign o_last      = r_q[r_rd].last;

    `STT_ASSERT_IMPLY(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= Q_CW'(Q_DEPTH))
    `STT_ASSERT_IMPLY(a_room, i_clk, i_rst_n, acc, r_cnt <= Q_CW'(Q_DEPTH - 2))
    `STT_ASSERT_IMPLY(a_err_quiet, i_clk, i_rst_n, acc && r_mode == MODE_ERROR, n_push == 2'd0)
    `STT_ASSERT_NEXT(a_drain, i_clk, i_rst_n, pop && !(acc && n_push != 2'd0),
        r_cnt == $past(r_cnt) - Q_CW'(1))

endmodule

[tb/source_text_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Feeds byte streams with end markers into the tokenizer and checks every
// token word against an in-bench lexer: directed statements, mode switches
// and error recovery, output back-pressure, then random well-formed texts
// mixed with noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;
    import stt_pkg::*;

    localparam int  RANDOM_ITEMS = 1300;
    localparam int  RX_LONG_HOLD = 120;
    localparam int  PRINT_CAP    = 40;
    localparam int  TAIL_CYCLES  = 16;
    localparam time TIMEOUT_NS   = 10_000_000;

    typedef enum logic [1:0] {LEX_IDLE, LEX_NUMBER, LEX_WORD, LEX_ERROR} lex_mode_e;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_byte    i_ch;
    logic     i_end_of_text;
    logic     o_valid;
    logic     i_stall;
    t_kind    o_kind;
    t_value   o_value;
    logic     o_overflow;
    t_out_pos o_start_pos;
    t_out_pos o_end_pos;
    logic     o_last;

    // lexer state mirrored by the bench
    lex_mode_e  lex_mode;
    t_value     num_acc;
    logic       num_sat;
    t_pos       tok_start;
    t_pos       byte_pos;
    t_byte      word_head [3];
    logic [2:0] word_len;

    t_tok  expected_tokens [$];
    t_byte src_bytes [$];
    int    live_items;
    int    words_seen;
    int    mismatches;
    bit    tx_steady;
    bit    rx_steady;
    bit    rx_hold_req;

    source_text_tokenizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_overflow    (o_overflow),
        .o_start_pos   (o_start_pos),
        .o_end_pos     (o_end_pos),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- lexer model ----------------

    function automatic void lex_reset();
        lex_mode     = LEX_IDLE;
        num_acc      = '0;
        num_sat      = 1'b0;
        tok_start    = '0;
        byte_pos     = '0;
        word_head[0] = '0;
        word_head[1] = '0;
        word_head[2] = '0;
        word_len     = '0;
    endfunction

    function automatic void push_token(t_kind k, t_value v, logic ovf, t_pos s, t_pos e);
        t_tok t;
        t.kind      = k;
        t.value     = v;
        t.overflow  = ovf;
        t.start_pos = t_out_pos'(s);
        t.end_pos   = t_out_pos'(e);
        t.last      = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void flush_pending();
        t_kind k;
        if (lex_mode == LEX_NUMBER) begin
            push_token(K_INT, num_acc, num_sat, tok_start, byte_pos);
        end else if (lex_mode == LEX_WORD) begin
            k = K_IDENT;
            if (word_len == 3'd3) begin
                if (word_head[0] == "v" && word_head[1] == "a" && word_head[2] == "r")
                    k = K_VAR;
                else if (word_head[0] == "i" && word_head[1] == "n" && word_head[2] == "t")
                    k = K_KWINT;
            end
            push_token(k, '0, 1'b0, tok_start, byte_pos);
        end
    endfunction

    function automatic void add_digit(logic [3:0] d);
        if (num_sat || num_acc > (VALUE_MAX - t_value'(d)) / t_value'(10)) begin
            num_acc = VALUE_MAX;
            num_sat = 1'b1;
        end else begin
            num_acc = num_acc * t_value'(10) + t_value'(d);
        end
    endfunction

    function automatic void add_letter(t_byte c);
        if (word_len < 3'd3) word_head[word_len[1:0]] = c;
        if (word_len < 3'd4) word_len = word_len + 3'd1;
    endfunction

    function automatic void lex_step(t_byte c, logic eot);
        int   prev_size;
        bit   digit;
        bit   alpha;
        bit   blank;
        t_pos nxt;
        prev_size = expected_tokens.size();
        digit     = (c >= "0" && c <= "9");
        alpha     = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        blank     = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
        live_items++;
        if (eot) begin
            if (lex_mode != LEX_ERROR) begin
                flush_pending();
                push_token(K_END, '0, 1'b0, byte_pos, byte_pos);
            end
            lex_reset();
        end else if (lex_mode == LEX_NUMBER && digit) begin
            add_digit(4'(c - "0"));
            byte_pos = byte_pos + t_pos'(1);
        end else if (lex_mode == LEX_WORD && (alpha || digit)) begin
            add_letter(c);
            byte_pos = byte_pos + t_pos'(1);
        end else if (lex_mode != LEX_ERROR) begin
            flush_pending();
            lex_mode = LEX_IDLE;
            nxt = byte_pos + t_pos'(1);
            if (digit) begin
                lex_mode  = LEX_NUMBER;
                tok_start = byte_pos;
                num_acc   = '0;
                num_sat   = 1'b0;
                add_digit(4'(c - "0"));
            end else if (alpha) begin
                lex_mode     = LEX_WORD;
                tok_start    = byte_pos;
                word_head[0] = '0;
                word_head[1] = '0;
                word_head[2] = '0;
                word_len     = '0;
                add_letter(c);
            end else if (c == CH_EQUALS) begin
                push_token(K_EQUALS, '0, 1'b0, byte_pos, nxt);
            end else if (c == CH_SEMI) begin
                push_token(K_SEMI, '0, 1'b0, byte_pos, nxt);
            end else if (c == CH_COLON) begin
                push_token(K_COLON, '0, 1'b0, byte_pos, nxt);
            end else if (!blank) begin
                push_token(K_ERROR, '0, 1'b0, byte_pos, nxt);
                lex_mode = LEX_ERROR;
            end
            byte_pos = nxt;
        end
        if (expected_tokens.size() > prev_size)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: word %0d: %s", $time, words_seen, what);
    endtask

    always @(posedge i_clk) begin
        t_tok want;
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected word, kind %0d", o_kind));
            end else begin
                want = expected_tokens.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
                if (o_value !== want.value)
                    report_mismatch($sformatf("value %0h, want %0h", o_value, want.value));
                if (o_overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, want %0b",
                                              o_overflow, want.overflow));
                if (o_start_pos !== want.start_pos)
                    report_mismatch($sformatf("start_pos %0d, want %0d",
                                              o_start_pos, want.start_pos));
                if (o_end_pos !== want.end_pos)
                    report_mismatch($sformatf("end_pos %0d, want %0d",
                                              o_end_pos, want.end_pos));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin : token_sink
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (RX_LONG_HOLD) @(posedge i_clk);
            end else begin
                hold = rx_steady ? 0 : $urandom_range(0, 19);
                if (hold != 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // ---------------- sender ----------------

    task automatic send_word(input t_byte c, input logic eot);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ch          <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        lex_step(c, eot);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_word(t_byte'(s[i]), 1'b0);
    endtask

    task automatic send_source();
        foreach (src_bytes[i]) send_word(src_bytes[i], 1'b0);
        send_word(t_byte'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    // ---------------- text generation ----------------

    function automatic t_byte rand_letter();
        if ($urandom_range(0, 1) == 0) return t_byte'("a" + $urandom_range(0, 25));
        return t_byte'("A" + $urandom_range(0, 25));
    endfunction

    function automatic void push_chars(string s);
        for (int i = 0; i < s.len(); i++) src_bytes.push_back(t_byte'(s[i]));
    endfunction

    function automatic void build_text();
        int    shape;
        int    r;
        string w;
        src_bytes.delete();
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 12))
                src_bytes.push_back(t_byte'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 14)) begin
            r = $urandom_range(0, 9);
            case (r)
                0: begin
                    case ($urandom_range(0, 9))
                        0: w = "var";
                        1: w = "int";
                        2: w = "va";
                        3: w = "in";
                        4: w = "vars";
                        5: w = "int0";
                        6: w = "Var";
                        7: w = "INT";
                        8: w = "v";
                        default: w = "i9";
                    endcase
                    push_chars(w);
                end
                1, 2, 3: begin
                    src_bytes.push_back(rand_letter());
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 3) == 0)
                            src_bytes.push_back(t_byte'("0" + $urandom_range(0, 9)));
                        else
                            src_bytes.push_back(rand_letter());
                    end
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: w = "9223372036854775807";
                        1: w = "9223372036854775808";
                        2: w = "92233720368547758070";
                        default: w = "0000000000000000000009";
                    endcase
                    push_chars(w);
                end
                5: repeat ($urandom_range(18, 24))
                    src_bytes.push_back(t_byte'("0" + $urandom_range(0, 9)));
                6: repeat ($urandom_range(1, 6))
                    src_bytes.push_back(t_byte'("0" + $urandom_range(0, 9)));
                7: src_bytes.push_back(CH_EQUALS);
                8: src_bytes.push_back(CH_SEMI);
                default: src_bytes.push_back(CH_COLON);
            endcase
            repeat ($urandom_range(0, 2)) begin
                r = $urandom_range(0, 5);
                src_bytes.push_back(r == 0 ? 8'h20 : t_byte'(8 + r));
            end
        end
        if (shape == 1)
            src_bytes.insert($urandom_range(0, src_bytes.size()),
                             t_byte'($urandom_range(0, 255)));
    endfunction

    // ---------------- tests ----------------

    task automatic test_statement_tokens();
        send_string("var x1:int=9;");
        send_word(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_mode_switch_and_error();
        // digit then letter, NUL ends the word with an error, z is ignored; after the end marker 0xff errors again
        send_string("\t8q");
        send_word(8'h00, 1'b0);
        send_word("z", 1'b0);
        send_word(8'hff, 1'b1);
        send_word(8'hff, 1'b0);
        send_word(8'h7f, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_bytes.delete();
        for (int i = 0; i < 30; i++) begin
            src_bytes.push_back(t_byte'("a" + i % 26));
            src_bytes.push_back(CH_SEMI);
        end
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        send_source();
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_texts();
        int target;
        target = live_items + RANDOM_ITEMS;
        while (live_items < target) begin
            build_text();
            tx_steady = ($urandom_range(0, 5) == 0);
            rx_steady = ($urandom_range(0, 5) == 0);
            send_source();
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_ch          <= '0;
        i_end_of_text <= 1'b0;
        live_items  = 0;
        words_seen  = 0;
        mismatches  = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_req = 1'b0;
        lex_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_statement_tokens();
        test_mode_switch_and_error();
        test_output_backpressure();
        test_random_texts();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("source_text_tokenizer test passed");
        else
            $display("source_text_tokenizer test failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("source_text_tokenizer test failed");
        $finish;
    end

endmodule
